/* rtl/joystick_differential_drive_mixer_macros.svh */
// Assertion macros for the joystick differential drive mixer checker.
// Depends on nothing; included by the checker file.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JDDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jddm assertion failed");

// Next-cycle implication, disabled during reset.
`define JDDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jddm assertion failed");

`endif

/* rtl/jddm_pkg.sv */
// Shared types and constants of the joystick differential drive mixer.
// Depends on nothing; used by the interfaces, the top level and the checker.
package jddm_pkg;

	localparam int unsigned TIMER_W = 14;
	localparam int unsigned STEP_W  = 10;
	localparam int unsigned DZ_W    = 7;
	localparam int unsigned CFG_W   = 14;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [7:0] NEUTRAL   = 8'(255 / 2);
	localparam logic [7:0] SPEED_MAX = 8'd254;
	localparam logic [7:0] SPEED_MIN = 8'd0;
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(500);
	localparam logic [STEP_W-1:0]  STEP_RESET    = STEP_W'(10);
	localparam logic [DZ_W-1:0]    DZ_RESET      = DZ_W'(10);

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd2;

	typedef struct packed {
		logic       msg_valid;
		logic       msg_initialized;
		logic [7:0] joy_x;
		logic [7:0] joy_y;
		logic       turn_right_button;
		logic       turn_left_button;
	} tick_item_t;

	typedef struct packed {
		logic       motors_set;
		logic [7:0] speed_left;
		logic [7:0] speed_right;
	} result_item_t;

endpackage

/* rtl/jddm_if.sv */
// Valid/ready channel interfaces for control ticks and motor results.
// Depends on jddm_pkg.
interface jddm_tick_if;
	logic                valid;
	logic                ready;
	jddm_pkg::tick_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

interface jddm_result_if;
	logic                  valid;
	logic                  ready;
	jddm_pkg::result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

/* rtl/joystick_differential_drive_mixer.sv */
// Joystick differential drive mixer: one control tick in, one motor result out per item,
// at a sustained rate of one item per clock cycle while the output is not stalled. An
// accepted tick lands in an input register; in the following cycle the arcade mix, dead
// zone, button override and silence timer update run in one pass, and the result is loaded
// into the output register once that register can advance, which raises result valid. The
// silence timer is updated as each item moves into the output register, which keeps items
// in order; a stalled output holds both stages and drops input ready once the input
// register is full.
// Depends on jddm_pkg and jddm_if.
module joystick_differential_drive_mixer (
	input  logic                           clk,
	input  logic                           arst_n,
	jddm_tick_if.sink                      tick,
	jddm_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jddm_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [jddm_pkg::TIMER_W-1:0] timeout_limit_q;
	logic [jddm_pkg::STEP_W-1:0]  tick_step_q;
	logic [jddm_pkg::DZ_W-1:0]    dead_zone_q;
	logic [jddm_pkg::TIMER_W-1:0] silence_timer_q;
	logic [jddm_pkg::TIMER_W-1:0] timer_next;

	logic                 tick_valid_s1;
	jddm_pkg::tick_item_t tick_data_s1;
	logic                   result_valid_s2;
	jddm_pkg::result_item_t result_data_s2;
	jddm_pkg::result_item_t result_next;

	logic advance;

	logic signed [9:0] cx, cy, cx_half, ax, ay, l_mix, r_mix;
	logic              outside;
	logic [jddm_pkg::TIMER_W:0] timer_sum;

	function automatic logic [7:0] clamp_speed(input logic signed [9:0] v);
		logic signed [10:0] s;
		s = {v[9], v} + 11'sd127;
		if (s < 11'sd0)
			return jddm_pkg::SPEED_MIN;
		else if (s > 11'sd254)
			return jddm_pkg::SPEED_MAX;
		else
			return s[7:0];
	endfunction

	assign advance      = !result_valid_s2 || result.ready;
	assign tick.ready   = !tick_valid_s1 || advance;
	assign result.valid = result_valid_s2;
	assign result.data  = result_data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= jddm_pkg::TIMEOUT_RESET;
			tick_step_q     <= jddm_pkg::STEP_RESET;
			dead_zone_q     <= jddm_pkg::DZ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jddm_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata;
				jddm_pkg::CFG_TICK_STEP:     tick_step_q <= cfg_wdata[jddm_pkg::STEP_W-1:0];
				jddm_pkg::CFG_DEAD_ZONE:     dead_zone_q <= cfg_wdata[jddm_pkg::DZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			tick_valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			tick_data_s1 <= tick.data;
		end
	end

	always_comb begin
		cx      = $signed({2'b00, tick_data_s1.joy_x}) - 10'sd127;
		cy      = $signed({2'b00, tick_data_s1.joy_y}) - 10'sd127;
		cx_half = (cx + $signed({9'd0, cx[9]})) >>> 1;
		ax      = cx[9] ? -cx : cx;
		ay      = cy[9] ? -cy : cy;
		outside = (ax > $signed({3'b000, dead_zone_q})) ||
			(ay > $signed({3'b000, dead_zone_q}));

		l_mix = 10'sd0;
		r_mix = 10'sd0;
		if (outside) begin
			if (cy > 10'sd0) begin
				l_mix = (cx > 10'sd0) ? ((cx > cy) ? cx : cy) : (cy + cx_half);
				r_mix = (cx > 10'sd0) ? (cy - cx_half) : ((-cx > cy) ? -cx : cy);
			end else begin
				l_mix = (cx > 10'sd0) ? ((-cx < cy) ? -cx : cy) : (cy - cx_half);
				r_mix = (cx > 10'sd0) ? (cy + cx_half) : ((cx < cy) ? cx : cy);
			end
		end

		timer_sum  = {1'b0, silence_timer_q} +
			{{(jddm_pkg::TIMER_W + 1 - jddm_pkg::STEP_W){1'b0}}, tick_step_q};
		timer_next = silence_timer_q;

		result_next.motors_set  = 1'b0;
		result_next.speed_left  = jddm_pkg::NEUTRAL;
		result_next.speed_right = jddm_pkg::NEUTRAL;

		if (tick_data_s1.msg_valid) begin
			timer_next = '0;
			if (tick_data_s1.msg_initialized) begin
				result_next.motors_set = 1'b1;
				if (tick_data_s1.turn_right_button) begin
					result_next.speed_left  = jddm_pkg::SPEED_MAX;
					result_next.speed_right = jddm_pkg::SPEED_MIN;
				end else if (tick_data_s1.turn_left_button) begin
					result_next.speed_left  = jddm_pkg::SPEED_MIN;
					result_next.speed_right = jddm_pkg::SPEED_MAX;
				end else begin
					result_next.speed_left  = clamp_speed(l_mix);
					result_next.speed_right = clamp_speed(r_mix);
				end
			end
		end else if (silence_timer_q >= timeout_limit_q) begin
			result_next.motors_set = 1'b1;
		end else begin
			timer_next = timer_sum[jddm_pkg::TIMER_W] ? jddm_pkg::TIMER_MAX :
				timer_sum[jddm_pkg::TIMER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
			silence_timer_q <= '0;
		end else if (advance) begin
			result_valid_s2 <= tick_valid_s1;
			if (tick_valid_s1) begin
				silence_timer_q <= timer_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tick_valid_s1) begin
			result_data_s2 <= result_next;
		end
	end

endmodule

/* rtl/jddm_checker.sv */
// Port-level checker for the joystick differential drive mixer, bound to the top level.
// Depends on jddm_pkg and the assertion macro header.
`include "joystick_differential_drive_mixer_macros.svh"

module jddm_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   tick_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input jddm_pkg::result_item_t result_data
);

	logic stalled;
	logic motors_idle;
	logic speeds_neutral;
	logic speeds_in_range;

	assign stalled         = result_valid && !result_ready;
	assign motors_idle     = result_valid && !result_data.motors_set;
	assign speeds_neutral  = (result_data.speed_left == jddm_pkg::NEUTRAL) &&
		(result_data.speed_right == jddm_pkg::NEUTRAL);
	assign speeds_in_range = (result_data.speed_left <= jddm_pkg::SPEED_MAX) &&
		(result_data.speed_right <= jddm_pkg::SPEED_MAX);

	`JDDM_ASSERT_NEXT(a_result_hold, clk, arst_n, stalled, result_valid && $stable(result_data))
	`JDDM_ASSERT_NOW(a_idle_neutral, clk, arst_n, motors_idle, speeds_neutral)
	`JDDM_ASSERT_NOW(a_speed_range, clk, arst_n, result_valid, speeds_in_range)
	`JDDM_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !result_valid, tick_ready)

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
